@@ sv/interarrival_tail_exponent_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks on the tail estimator ports.
// ----------------------------------------------------------------------------
`ifndef INTERARRIVAL_TAIL_EXPONENT_MACROS_SVH
`define INTERARRIVAL_TAIL_EXPONENT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IATE_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IATE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/iate_pkg.sv @@
// ----------------------------------------------------------------------------
// iate_pkg
// Shared constants, codes and types of the interarrival tail estimator.
// ----------------------------------------------------------------------------
package iate_pkg;

  localparam int GAP_DEPTH_DEF = 2048;
  localparam int MAX_TAIL_DEF  = 128;
  localparam int MIN_TAIL      = 5;
  localparam int MIN_ENTRIES   = 5;

  localparam int TS_W    = 48;  // timestamps and gaps
  localparam int FRAC_W  = 32;  // log2 fraction bits
  localparam int EXP_W   = 6;   // log2 integer bits
  localparam int LOG_W   = EXP_W + FRAC_W;
  localparam int WIN_W   = 22;
  localparam int TAIL_W  = 8;
  localparam int RES_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 22;
  localparam int SPAN_W  = 32;

  localparam logic [9:0]        US_PER_MS = 10'd1000;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [WIN_W-1:0]  WIN_RST   = 22'd3000;
  localparam logic [TAIL_W-1:0] TAIL_RST  = 8'd20;

  localparam logic [CIDX_W-1:0] REG_WINDOW = 8'd0;
  localparam logic [CIDX_W-1:0] REG_TAIL   = 8'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_FEW_GAPS = 2'd2,
    ST_DEGEN    = 2'd3
  } status_t;

  typedef struct packed {
    logic            clear;
    logic            shift;
    logic            ins;
    logic [TS_W-1:0] g;
  } cell_ctl_t;

endpackage

@@ sv/iate_cell.sv @@
// ----------------------------------------------------------------------------
// iate_cell
// One slot of the sorted top-gap chain: inserts push right, shifts pull left.
// ----------------------------------------------------------------------------
module iate_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iate_pkg::cell_ctl_t           ctl,
  input  logic [iate_pkg::TS_W-1:0]     left_val,
  input  logic                          left_vld,
  input  logic [iate_pkg::TS_W-1:0]     right_val,
  input  logic                          right_vld,
  output logic [iate_pkg::TS_W-1:0]     val_r,
  output logic                          vld_r
);

  logic gt_self;
  logic gt_left;

  assign gt_self = !vld_r || (ctl.g > val_r);
  assign gt_left = !left_vld || (ctl.g > left_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= right_vld;
    end else if (ctl.ins) begin
      if (gt_left) begin
        vld_r <= left_vld;
      end else if (gt_self) begin
        vld_r <= 1'b1;
      end
    end
  end

  // take left value if the gap outranks it; else the gap, if above this slot
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= right_val;
    end else if (ctl.ins && !ctl.clear) begin
      if (gt_left) begin
        val_r <= left_val;
      end else if (gt_self) begin
        val_r <= ctl.g;
      end
    end
  end

endmodule

@@ sv/iate_log2.sv @@
// ----------------------------------------------------------------------------
// iate_log2
// Iterative log2 in Q.32: shift-by-one normalize, then 32 squaring steps.
// ----------------------------------------------------------------------------
module iate_log2 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [iate_pkg::TS_W-1:0]      x,
  output logic                           done_r,
  output logic [iate_pkg::LOG_W-1:0]     res
);

  localparam int TS_W   = iate_pkg::TS_W;
  localparam int FRAC_W = iate_pkg::FRAC_W;
  localparam int EXP_W  = iate_pkg::EXP_W;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t                  st_r, st_nxt;
  logic [TS_W-1:0]          n_r, n_nxt;
  logic [EXP_W-1:0]         sh_r, sh_nxt;
  logic [FRAC_W-1:0]        m_r, m_nxt;
  logic [FRAC_W-1:0]        frac_r, frac_nxt;
  logic [4:0]               it_r, it_nxt;
  logic                     done_nxt;
  logic [2*FRAC_W-1:0]      sq;
  logic [FRAC_W:0]          sqs;

  assign sq  = m_r * m_r;
  assign sqs = sq[2*FRAC_W-1:FRAC_W-1];
  assign res = {EXP_W'(TS_W - 1) - sh_r, frac_r};

  always_comb begin
    st_nxt   = st_r;
    n_nxt    = n_r;
    sh_nxt   = sh_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    it_nxt   = it_r;
    done_nxt = 1'b0;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          n_nxt  = x;
          sh_nxt = '0;
          st_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (n_r[TS_W-1] || sh_r == EXP_W'(TS_W - 1)) begin
          m_nxt  = n_r[TS_W-1:TS_W-FRAC_W];
          it_nxt = '0;
          st_nxt = L_SQ;
        end else begin
          n_nxt  = n_r << 1;
          sh_nxt = sh_r + 1'b1;
        end
      end
      L_SQ: begin
        if (sqs[FRAC_W]) begin
          m_nxt    = sqs[FRAC_W:1];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          m_nxt    = sqs[FRAC_W-1:0];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == 5'd31) begin
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    sh_r   <= sh_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    it_r   <= it_nxt;
  end

endmodule

@@ sv/iate_div.sv @@
// ----------------------------------------------------------------------------
// iate_div
// Restoring divider, one quotient bit per cycle, 64-bit divisor.
// ----------------------------------------------------------------------------
module iate_div #(
  parameter int NW = 56
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [63:0]   den,
  output logic          done_r,
  output logic [NW-1:0] quo_r
);

  localparam int CNT_W = $clog2(NW + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [63:0]       rem_r;
  logic [63:0]       den_r;
  logic [64:0]       rem_sh;
  logic              ge;
  logic [64:0]       diff;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in from the bottom as dividend bits shift out the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rem_sh[63:0];
      quo_r <= {quo_r[NW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

@@ sv/interarrival_tail_exponent.sv @@
// ----------------------------------------------------------------------------
// interarrival_tail_exponent
// Hill-style tail index of trade interarrival gaps over a time window.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  beats carry time-and-sales entries in time order: tdata is the
//   microsecond timestamp, tuser the trade flag, tlast the end-of-set mark.
//   Each non-final entry is accepted while idle, so a set loads at one beat
//   per clock. The beat with tlast set closes the set and starts the
//   estimate; in_tready stays low until the result is in the output register.
//   The estimate then reads the gaps inside the window, one gap memory
//   read per cycle, runs the shared log2 unit on each of the k clamped
//   tail gaps, with w <= 47 normalize shifts in each log, and, unless the
//   result is degenerate, ends with the 56-step divider. A short set skips
//   these steps and goes straight to the result.
//   out_* carries one beat per set: tdata is the Q16.16 estimate, tuser the
//   status. The output register holds it while out_tready is low, and the
//   block keeps loading the next set meanwhile; a finished estimate waits
//   for the slot to free.
//   cfg_* writes window_ms (index 0) or tail_count (index 1); always ready.
//   Reset (rst_n low, synchronous) clears the set state and loads the
//   register defaults; the gap memory needs no clearing pass.
// ----------------------------------------------------------------------------
module interarrival_tail_exponent #(
  parameter int GAP_DEPTH = iate_pkg::GAP_DEPTH_DEF,
  parameter int MAX_TAIL  = iate_pkg::MAX_TAIL_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input entries
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iate_pkg::TS_W-1:0]        in_tdata,   // [47:0] timestamp_us
  input  logic [0:0]                       in_tuser,   // [0] is_trade
  input  logic                             in_tlast,   // last_entry
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iate_pkg::RES_W-1:0]       out_tdata,  // [31:0] tail_exponent
  output logic [iate_pkg::STAT_W-1:0]      out_tuser,  // [1:0] status
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iate_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [iate_pkg::CDATA_W-1:0]     cfg_data
);

  localparam int TS_W   = iate_pkg::TS_W;
  localparam int LOG_W  = iate_pkg::LOG_W;
  localparam int FRAC_W = iate_pkg::FRAC_W;
  localparam int RES_W  = iate_pkg::RES_W;
  localparam int AW     = $clog2(GAP_DEPTH);
  localparam int CW     = AW + 1;
  localparam int KW     = $clog2(MAX_TAIL + 1);
  localparam int NW     = KW + TS_W;
  localparam int SW     = LOG_W + KW;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_SCAN = 12'b000000000010,
    S_EVAL = 12'b000000000100,
    S_LGO  = 12'b000000001000,
    S_LWT  = 12'b000000010000,
    S_MUL  = 12'b000000100000,
    S_SUB  = 12'b000001000000,
    S_LNM  = 12'b000010000000,
    S_LNS  = 12'b000100000000,
    S_CHK  = 12'b001000000000,
    S_DIV  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [iate_pkg::WIN_W-1:0]  win_r;
  logic [iate_pkg::TAIL_W-1:0] tail_r;

  // set state
  logic [AW-1:0]   wp_r, wp_nxt, wp_upd;
  logic [CW-1:0]   gcnt_r, gcnt_nxt, gcnt_upd;
  logic [TS_W-1:0] prev_r, prev_nxt;
  logic            have_r, have_nxt;
  logic [2:0]      ecnt_r, ecnt_nxt, ecnt_upd;

  // gap memory: {start time, gap}
  logic [2*TS_W-1:0] gmem [GAP_DEPTH];
  logic              wr_en;
  logic [TS_W-1:0]   wr_gap;
  logic [2*TS_W-1:0] rd_q_r;

  // estimate working registers
  logic [TS_W-1:0]    ts_r;
  logic [iate_pkg::SPAN_W-1:0] span_r;
  logic [KW-1:0]      k_r, k_clamp, k_m1;
  logic [CW-1:0]      cnt_r, issued_r, nwin_r;
  logic [AW-1:0]      raddr_r;
  logic               rvld_r, stop_r;
  logic               issue, outside, ins;
  logic [KW-1:0]      j_r;
  logic [SW-1:0]      sum_r, prod_r, s2_r;
  logic [LOG_W-1:0]   lxk_r;
  logic               xz_r;
  logic [63:0]        phi_r, plo_r, sln_r;
  logic [31:0]        s2_hi;

  // result staging and output register
  logic [RES_W-1:0]   fin_res_r;
  iate_pkg::status_t  fin_stat_r;
  logic               out_vld_r;
  logic [RES_W-1:0]   out_data_r;
  logic [iate_pkg::STAT_W-1:0] out_stat_r;
  logic               out_load;

  // sub-unit hookups
  iate_pkg::cell_ctl_t ctl;
  logic [TS_W-1:0]     cval [MAX_TAIL];
  logic                cvld [MAX_TAIL];
  logic                log_start, log_done;
  logic [LOG_W-1:0]    log_res;
  logic                div_start, div_done;
  logic [NW-1:0]       div_quo;

  logic acc, last_acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign last_acc  = acc && in_tlast;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= iate_pkg::WIN_RST;
      tail_r <= iate_pkg::TAIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == iate_pkg::REG_WINDOW) begin
        win_r <= cfg_data[iate_pkg::WIN_W-1:0];
      end else if (cfg_index == iate_pkg::REG_TAIL) begin
        tail_r <= cfg_data[iate_pkg::TAIL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------- entry intake
  assign wr_en  = acc && in_tuser[0] && have_r;
  assign wr_gap = (in_tdata >= prev_r) ? (in_tdata - prev_r) : '0;

  always_comb begin
    wp_upd   = wp_r;
    gcnt_upd = gcnt_r;
    ecnt_upd = (ecnt_r < 3'(iate_pkg::MIN_ENTRIES)) ? ecnt_r + 1'b1 : ecnt_r;
    if (wr_en) begin
      wp_upd = (wp_r == AW'(GAP_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (gcnt_r < CW'(GAP_DEPTH)) begin
        gcnt_upd = gcnt_r + 1'b1;
      end
    end
    wp_nxt   = wp_r;
    gcnt_nxt = gcnt_r;
    ecnt_nxt = ecnt_r;
    prev_nxt = prev_r;
    have_nxt = have_r;
    if (acc) begin
      wp_nxt   = wp_upd;
      gcnt_nxt = gcnt_upd;
      ecnt_nxt = ecnt_upd;
      if (in_tuser[0]) begin
        prev_nxt = in_tdata;
        have_nxt = 1'b1;
      end
      // drop the set state once the final entry is in
      if (in_tlast) begin
        wp_nxt   = '0;
        gcnt_nxt = '0;
        ecnt_nxt = '0;
        prev_nxt = '0;
        have_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      gcnt_r <= '0;
      ecnt_r <= '0;
      prev_r <= '0;
      have_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      gcnt_r <= gcnt_nxt;
      ecnt_r <= ecnt_nxt;
      prev_r <= prev_nxt;
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gmem[wp_r] <= {prev_r, wr_gap};
    end
    rd_q_r <= gmem[raddr_r];
  end

  // --------------------------------------------------------- window scan
  always_comb begin
    if (int'(tail_r) > MAX_TAIL) begin
      k_clamp = KW'(MAX_TAIL);
    end else if (tail_r < 8'(iate_pkg::MIN_TAIL)) begin
      k_clamp = KW'(iate_pkg::MIN_TAIL);
    end else begin
      k_clamp = KW'(tail_r);
    end
  end

  assign k_m1    = k_r - KW'(1);
  assign issue   = (state_r == S_SCAN) && !stop_r && (issued_r != cnt_r);
  // a gap leaves the window once its earlier trade starts before T - span
  assign outside = ({1'b0, rd_q_r[2*TS_W-1:TS_W]} + (TS_W + 1)'(span_r))
                   < {1'b0, ts_r};
  assign ins     = (state_r == S_SCAN) && rvld_r && !stop_r && !outside;

  // ------------------------------------------------------------ top-k chain
  always_comb begin
    ctl.clear = last_acc;
    ctl.shift = (state_r == S_LGO);
    ctl.ins   = ins;
    ctl.g     = rd_q_r[TS_W-1:0];
  end

  for (genvar i = 0; i < MAX_TAIL; i++) begin : g_chain
    logic [TS_W-1:0] lv, rv;
    logic            lvd, rvd;
    if (i == 0) begin : g_head
      assign lv  = '1;
      assign lvd = 1'b1;
    end else begin : g_mid
      assign lv  = cval[i-1];
      assign lvd = cvld[i-1];
    end
    if (i == MAX_TAIL - 1) begin : g_tail
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_body
      assign rv  = cval[i+1];
      assign rvd = cvld[i+1];
    end
    iate_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_val  (lv),
      .left_vld  (lvd),
      .right_val (rv),
      .right_vld (rvd),
      .val_r     (cval[i]),
      .vld_r     (cvld[i])
    );
  end

  // -------------------------------------------------------- arithmetic units
  assign log_start = (state_r == S_LGO);

  iate_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (cval[0]),
    .done_r (log_done),
    .res    (log_res)
  );

  assign div_start = (state_r == S_CHK) && (sln_r != '0);

  iate_div #(.NW(NW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    ({k_r, {TS_W{1'b0}}}),
    .den    (sln_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  assign s2_hi = 32'(s2_r >> FRAC_W);

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (last_acc) begin
          if (ecnt_upd < 3'(iate_pkg::MIN_ENTRIES)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((stop_r || issued_r == cnt_r) && !rvld_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: state_nxt = (nwin_r <= CW'(k_r)) ? S_FIN : S_LGO;
      S_LGO:  state_nxt = S_LWT;
      S_LWT: begin
        if (log_done) begin
          state_nxt = (j_r == k_m1) ? S_MUL : S_LGO;
        end
      end
      S_MUL:  state_nxt = xz_r ? S_FIN : S_SUB;
      S_SUB:  state_nxt = S_LNM;
      S_LNM:  state_nxt = S_LNS;
      S_LNS:  state_nxt = S_CHK;
      S_CHK:  state_nxt = (sln_r == '0) ? S_FIN : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rvld_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= issue;
      if (last_acc) begin
        stop_r <= 1'b0;
      end else if (state_r == S_SCAN && rvld_r && outside) begin
        stop_r <= 1'b1;
      end
    end
  end

  // datapath registers of the estimate
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (last_acc) begin
          ts_r       <= in_tdata;
          span_r     <= iate_pkg::SPAN_W'(win_r) * iate_pkg::SPAN_W'(iate_pkg::US_PER_MS);
          k_r        <= k_clamp;
          cnt_r      <= gcnt_upd;
          raddr_r    <= (wp_upd == '0) ? AW'(GAP_DEPTH - 1) : wp_upd - 1'b1;
          issued_r   <= '0;
          nwin_r     <= '0;
          fin_res_r  <= '0;
          fin_stat_r <= iate_pkg::ST_SHORT;
        end
      end
      S_SCAN: begin
        if (issue) begin
          issued_r <= issued_r + 1'b1;
          raddr_r  <= (raddr_r == '0) ? AW'(GAP_DEPTH - 1) : raddr_r - 1'b1;
        end
        if (ins) begin
          nwin_r <= nwin_r + 1'b1;
        end
      end
      S_EVAL: begin
        j_r        <= '0;
        sum_r      <= '0;
        fin_res_r  <= '0;
        fin_stat_r <= iate_pkg::ST_FEW_GAPS;
      end
      S_LGO: begin
        xz_r <= (cval[0] == '0);
      end
      S_LWT: begin
        if (log_done) begin
          if (j_r == k_m1) begin
            lxk_r <= log_res;
          end else begin
            sum_r <= sum_r + SW'(log_res);
            j_r   <= j_r + 1'b1;
          end
        end
      end
      S_MUL: begin
        prod_r     <= SW'(lxk_r) * SW'(k_m1);
        fin_res_r  <= '0;
        fin_stat_r <= iate_pkg::ST_DEGEN;
      end
      S_SUB: s2_r <= sum_r - prod_r;
      S_LNM: begin
        phi_r <= s2_hi * iate_pkg::LN2_Q32;
        plo_r <= s2_r[FRAC_W-1:0] * iate_pkg::LN2_Q32;
      end
      S_LNS: sln_r <= phi_r + {32'd0, plo_r[63:32]};
      S_CHK: begin
        // all k-1 gaps equal the threshold: the estimate is unbounded
        fin_res_r  <= '1;
        fin_stat_r <= iate_pkg::ST_DEGEN;
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quo[NW-1:RES_W] != '0) begin
            fin_res_r  <= '1;
            fin_stat_r <= iate_pkg::ST_DEGEN;
          end else begin
            fin_res_r  <= div_quo[RES_W-1:0];
            fin_stat_r <= iate_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------- output register
  assign out_load = (state_r == S_FIN) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= fin_res_r;
      out_stat_r <= fin_stat_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

@@ sv/iate_chk.sv @@
// ----------------------------------------------------------------------------
// iate_chk
// Port-level checks of the tail estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "interarrival_tail_exponent_macros.svh"

module iate_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [iate_pkg::RES_W-1:0]       out_tdata,
  input logic [iate_pkg::STAT_W-1:0]      out_tuser
);

  // hold a stalled result beat
  `IATE_AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // short sets and sets with too few gaps report a zero estimate
  `IATE_AST_IMP(a_err_zero, out_tvalid && (out_tuser == iate_pkg::ST_SHORT || out_tuser == iate_pkg::ST_FEW_GAPS), out_tdata == '0, "error status with nonzero estimate")

  // the final beat of a set starts the estimate and closes the input
  `IATE_AST_NXT(a_last_busy, in_tvalid && in_tready && in_tlast, !in_tready, "input still open after final beat")

endmodule

bind interarrival_tail_exponent iate_chk u_iate_chk (.*);

@@ tb/tb_interarrival_tail_exponent.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interarrival_tail_exponent
// Self-checking bench for the trade gap tail estimator: a built-in predictor
// tracks the gap ring per set and computes the Hill estimate for each closing
// beat; results are compared field by field while both stream sides stall.
// ----------------------------------------------------------------------------
module tb_interarrival_tail_exponent;

  localparam int NGAP  = 2048;
  localparam int KMAX  = 128;
  localparam longint LIMIT = 3000000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [iate_pkg::TS_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [iate_pkg::RES_W-1:0] out_tdata;
  logic [iate_pkg::STAT_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [iate_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [iate_pkg::CDATA_W-1:0] cfg_data = '0;

  interarrival_tail_exponent uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [47:0] gaps [NGAP];
  logic [47:0] gap_starts [NGAP];
  int unsigned wr_ptr, n_gaps, n_entries;
  logic [47:0] prev_trade;
  bit have_prev;
  logic [47:0] largest [KMAX];
  logic [21:0] win_ms;
  logic [7:0] tail_k;

  typedef struct packed {
    logic [31:0] estimate;
    iate_pkg::status_t status;
  } estimate_t;
  estimate_t pending_estimates [$];

  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;        // no random idling in the closing stretch
  bit hold_off = 0;     // long receiver stall request
  int hold_cnt = 0;     // stall cycles spent, counted by the receiver
  logic [47:0] now_us = 0;

  function automatic logic [63:0] log2_fixed(logic [63:0] x);
    int e;
    logic [63:0] m, r;
    e = 0;
    while (e < 63 && (x >> e) > 1) e++;
    m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
    r = 64'(e) << 32;
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void clear_set_state();
    wr_ptr = 0; n_gaps = 0; prev_trade = 0; have_prev = 0; n_entries = 0;
  endfunction

  // Advance the predictor by one entry; push an estimate on a closing beat.
  function automatic void predict_entry(logic [47:0] ts, bit trade, bit last);
    int unsigned k, n, filled, idx, p;
    logic [63:0] span, xk, s2, sln, h, lx, lg, g;
    estimate_t est;
    est.estimate = 0;
    est.status = iate_pkg::ST_OK;
    n = 0; filled = 0; s2 = 0;
    if (n_entries < iate_pkg::MIN_ENTRIES) n_entries++;
    if (trade) begin
      if (have_prev) begin
        gaps[wr_ptr] = (ts >= prev_trade) ? ts - prev_trade : 48'd0;
        gap_starts[wr_ptr] = prev_trade;
        wr_ptr = (wr_ptr + 1) % NGAP;
        if (n_gaps < NGAP) n_gaps++;
      end
      prev_trade = ts;
      have_prev = 1;
    end
    if (!last) return;
    k = tail_k;
    if (k < iate_pkg::MIN_TAIL) k = iate_pkg::MIN_TAIL;
    if (k > KMAX) k = KMAX;
    span = 64'(win_ms) * 1000;
    if (n_entries < iate_pkg::MIN_ENTRIES) begin
      est.status = iate_pkg::ST_SHORT;
    end else begin
      for (int i = 0; i < n_gaps; i++) begin
        idx = (wr_ptr + NGAP - 1 - i) % NGAP;
        g = gaps[idx];
        if (64'(gap_starts[idx]) + span < 64'(ts)) break;
        n++;
        if (filled < k) p = filled++;
        else if (g > largest[k-1]) p = k - 1;
        else continue;
        while (p > 0 && largest[p-1] < g) begin
          largest[p] = largest[p-1];
          p--;
        end
        largest[p] = g;
      end
      if (n <= k) est.status = iate_pkg::ST_FEW_GAPS;
      else begin
        xk = largest[k-1];
        if (xk == 0) est.status = iate_pkg::ST_DEGEN;
        else begin
          lx = log2_fixed(xk);
          for (int i = 0; i + 1 < k; i++) begin
            lg = log2_fixed(largest[i]);
            if (lg > lx) s2 += lg - lx;
          end
          sln = (s2 >> 32) * 64'(iate_pkg::LN2_Q32)
                + (((s2 & 64'hFFFF_FFFF) * 64'(iate_pkg::LN2_Q32)) >> 32);
          if (sln == 0) begin
            est.estimate = '1; est.status = iate_pkg::ST_DEGEN;
          end else begin
            h = (64'(k) << 48) / sln;
            if (h > 64'hFFFF_FFFF) begin
              est.estimate = '1; est.status = iate_pkg::ST_DEGEN;
            end else est.estimate = h[31:0];
          end
        end
      end
    end
    clear_set_state();
    pending_estimates.push_back(est);
  endfunction

  // ---------------------------------------------------------------- drivers
  // Offer one beat and hold it until accepted; valid stays up for the next
  // beat and is dropped by idling or by wait_drained.
  task automatic send_entry(logic [47:0] ts, bit trade, bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ts;
    in_tuser <= trade;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_entry(ts, trade, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [iate_pkg::CIDX_W-1:0] idx,
                           logic [iate_pkg::CDATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == iate_pkg::REG_WINDOW) win_ms = val;
    else if (idx == iate_pkg::REG_TAIL) tail_k = val[7:0];
  endtask

  // Send one set: n entries, trades with probability ptrade/8, gaps up to gmax.
  task automatic send_set(int n, int ptrade, logic [47:0] gmax);
    for (int i = 0; i < n; i++) begin
      now_us = 48'(now_us + {$urandom, $urandom} % (64'(gmax) + 1));
      send_entry(now_us, $urandom_range(0, 7) < ptrade, i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // too few entries
    send_set(3, 8, 100);
    // too few gaps for k
    send_set(10, 8, 100);
    // equal gaps: zero log sum
    for (int i = 0; i < 30; i++) begin
      now_us += 50;
      send_entry(now_us, 1, i == 29);
    end
    // zero threshold gap: repeated timestamps
    for (int i = 0; i < 25; i++) send_entry(now_us, 1, i == 24);
    // decreasing timestamp stored as zero, plus non-trades and max timestamp
    send_entry(48'hFFFF_FFFF_FFFF, 1, 0);
    send_entry(48'h0, 1, 0);
    send_entry(48'h0, 0, 0);
    send_entry(48'hFFFF_FFFF_FFFF, 1, 0);
    send_entry(48'h5555_AAAA_5555, 0, 1);
    now_us = 1000;
  endtask

  task automatic test_settings();
    write_reg(iate_pkg::REG_WINDOW, 22'd3600000);
    write_reg(iate_pkg::REG_TAIL, 22'd0);
    send_set(40, 7, 5000);
    write_reg(iate_pkg::REG_TAIL, 22'd255);
    send_set(200, 8, 100000);
    write_reg(iate_pkg::REG_WINDOW, 22'd0);
    send_set(30, 8, 3);
    write_reg(iate_pkg::REG_WINDOW, 22'd1);
    write_reg(iate_pkg::REG_TAIL, 22'd5);
    send_set(40, 8, 300);
    write_reg(8'd7, 22'h3FFFFF);   // unknown index: ignored
    write_reg(iate_pkg::REG_WINDOW, 22'h3FFFFF);
    write_reg(iate_pkg::REG_TAIL, 22'd128);
    send_set(150, 8, 1000);
  endtask

  task automatic test_random_sets();
    int done, n;
    done = 0;
    while (done < 1150) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(iate_pkg::REG_WINDOW,
                  22'($urandom_range(0, 8) == 0 ? $urandom_range(0, 3) :
                      $urandom_range(1, 3000)));
        write_reg(iate_pkg::REG_TAIL,
                  22'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(5, 20)));
      end
      n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 6) : $urandom_range(15, 60);
      send_set(n, $urandom_range(5, 8), $urandom_range(0, 3) == 0 ? 48'hFFFF : 48'd3000);
      done += n;
    end
  endtask

  // The receiver stalls for HOLD_CYCLES while the sets keep coming, so the
  // output register fills, the next estimate waits and the input stalls.
  task automatic test_backpressure();
    hold_off = 1;
    send_set(20, 8, 100);
    send_set(20, 8, 100);
    send_set(20, 8, 100);
    hold_off = 0;
  endtask

  task automatic test_steady();
    quiet = 1;
    send_set(200, 8, 2000);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!hold_off) hold_cnt <= 0;
    else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
    if (hold_off && hold_cnt < HOLD_CYCLES) out_tready <= 1'b0;
    else if (!quiet && $urandom_range(0, 4) == 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // Compare each result beat with the oldest pending estimate.
  always @(posedge clk) begin
    estimate_t exp_est;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_estimates.size() == 0) begin
        $error("unexpected result beat: tail_exponent %h status %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_est = pending_estimates.pop_front();
        if (out_tdata !== exp_est.estimate) begin
          $error("tail_exponent expected %h actual %h", exp_est.estimate, out_tdata);
          errors++;
        end
        if (out_tuser !== exp_est.status) begin
          $error("status expected %0d actual %0d", exp_est.status, out_tuser);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    win_ms = 22'd3000;
    tail_k = 8'd20;
    clear_set_state();
    for (int i = 0; i < KMAX; i++) largest[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    test_random_sets();
    test_steady();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_estimates.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
